// ===== sv/iss_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package iss_pkg;

    // Storage geometry
    localparam int MAX_PAGES     = 64;
    localparam int MAX_PAGE_SIZE = 16;
    localparam int PAYLOAD_WIDTH = 64;
    localparam int KEY_W         = 32;
    localparam int PAGE_W        = $clog2(MAX_PAGES);
    localparam int SLOT_W        = $clog2(MAX_PAGE_SIZE);
    localparam int REC_DEPTH     = MAX_PAGES * MAX_PAGE_SIZE;
    localparam int REC_W         = KEY_W + PAYLOAD_WIDTH;

    // Config register widths
    localparam int MODE_W  = 2;
    localparam int PSIZE_W = 5;
    localparam int PCNT_W  = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    // Scan counter: holds up to MAX_PAGES + 1
    localparam int CNT_W = $clog2(MAX_PAGES + 2);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ORDER_MODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SIZE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_PAGE_FILL = 2'd3;

    // Order modes
    localparam logic [MODE_W-1:0] MODE_ASCENDING  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DESCENDING = 2'd1;

    // Request actions
    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

    typedef struct packed {
        logic                     action;
        logic [PAGE_W-1:0]        page_number;
        logic [SLOT_W-1:0]        slot;
        logic signed [KEY_W-1:0]  key;
        logic [PAYLOAD_WIDTH-1:0] payload;
    } iss_req_t;

    typedef struct packed {
        logic                     found;
        logic signed [KEY_W-1:0]  match_key;
        logic [PAYLOAD_WIDTH-1:0] match_payload;
    } iss_rsp_t;

    // Effective (clamped) configuration
    typedef struct packed {
        logic               desc;
        logic [PCNT_W-1:0]  n;
        logic [PSIZE_W-1:0] ps;
        logic [PSIZE_W-1:0] fill;
    } iss_cfg_t;

    // Compare unit result
    typedef struct packed {
        logic beyond;
        logic equal;
    } iss_cmp_t;

endpackage
`default_nettype wire

// ===== sv/indexed_sequential_search.sv =====
// Load requests are written into the stores on acceptance, produce no result; busy stays low.
// Search: an index scan over the page index, in descending mode a last-record
// check, and a page scan over the chosen page (one compare per cycle on a
// single comparator, registered memory reads). With no pages it misses in the index scan.
// done strobes for one cycle, in the same cycle that busy drops, and
// cannot be stalled; async reset restores config defaults, memories not cleared.
`timescale 1ns / 1ps
`default_nettype none
module indexed_sequential_search
    import iss_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire iss_req_t              req,
    output logic                       busy,
    output logic                       done,
    output iss_rsp_t                   rsp,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    iss_cfg_t                   cfg;
    logic                       idx_we;
    logic [PAGE_W-1:0]          idx_waddr;
    logic [KEY_W-1:0]           idx_wdata;
    logic [PAGE_W-1:0]          idx_raddr;
    logic [KEY_W-1:0]           idx_rdata;
    logic                       rec_we;
    logic [PAGE_W+SLOT_W-1:0]   rec_waddr;
    logic [REC_W-1:0]           rec_wdata;
    logic [PAGE_W+SLOT_W-1:0]   rec_raddr;
    logic [REC_W-1:0]           rec_rdata;

    // Configuration registers
    iss_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Page index: first key of each page
    iss_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_PAGES)
    ) u_idx_ram (
        .clk   (clk),
        .we    (idx_we),
        .waddr (idx_waddr),
        .wdata (idx_wdata),
        .raddr (idx_raddr),
        .rdata (idx_rdata)
    );

    // Record store: key and payload side by side
    iss_ram #(
        .WIDTH (REC_W),
        .DEPTH (REC_DEPTH)
    ) u_rec_ram (
        .clk   (clk),
        .we    (rec_we),
        .waddr (rec_waddr),
        .wdata (rec_wdata),
        .raddr (rec_raddr),
        .rdata (rec_rdata)
    );

    // Search sequencer
    iss_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req),
        .cfg       (cfg),
        .idx_rdata (idx_rdata),
        .rec_rdata (rec_rdata),
        .busy      (busy),
        .done      (done),
        .rsp       (rsp),
        .idx_we    (idx_we),
        .idx_waddr (idx_waddr),
        .idx_wdata (idx_wdata),
        .idx_raddr (idx_raddr),
        .rec_we    (rec_we),
        .rec_waddr (rec_waddr),
        .rec_wdata (rec_wdata),
        .rec_raddr (rec_raddr)
    );

endmodule
`default_nettype wire

// ===== sv/iss_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module iss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== sv/iss_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
module iss_cfg
    import iss_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output iss_cfg_t                   cfg
);

    logic [MODE_W-1:0]  order_mode_reg;
    logic [PSIZE_W-1:0] page_size_reg;
    logic [PCNT_W-1:0]  page_count_reg;
    logic [PSIZE_W-1:0] last_fill_reg;
    logic [PSIZE_W-1:0] ps_eff;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_mode_reg <= MODE_ASCENDING;
            page_size_reg  <= PSIZE_W'(MAX_PAGE_SIZE);
            page_count_reg <= '0;
            last_fill_reg  <= PSIZE_W'(MAX_PAGE_SIZE);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ORDER_MODE:     order_mode_reg <= cfg_data[MODE_W-1:0];
                CFG_PAGE_SIZE:      page_size_reg  <= cfg_data[PSIZE_W-1:0];
                CFG_PAGE_COUNT:     page_count_reg <= cfg_data[PCNT_W-1:0];
                CFG_LAST_PAGE_FILL: last_fill_reg  <= cfg_data[PSIZE_W-1:0];
                default:            ;
            endcase
        end
    end

    // Clamp to legal ranges
    always_comb
    begin
        if (page_size_reg == '0)
            ps_eff = PSIZE_W'(1);
        else if (page_size_reg > PSIZE_W'(MAX_PAGE_SIZE))
            ps_eff = PSIZE_W'(MAX_PAGE_SIZE);
        else
            ps_eff = page_size_reg;

        cfg.desc = (order_mode_reg == MODE_DESCENDING);
        cfg.n    = (page_count_reg > PCNT_W'(MAX_PAGES)) ? PCNT_W'(MAX_PAGES)
                                                         : page_count_reg;
        cfg.ps   = ps_eff;
        cfg.fill = (last_fill_reg == '0 || last_fill_reg > ps_eff) ? ps_eff
                                                                   : last_fill_reg;
    end

endmodule
`default_nettype wire

// ===== sv/iss_cmp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module iss_cmp
    import iss_pkg::*;
(
    input  wire logic signed [KEY_W-1:0] key,
    input  wire logic signed [KEY_W-1:0] ref_key,
    input  wire logic                    desc,
    output iss_cmp_t                     res
);

    // Shared magnitude compare; "beyond" means ref_key lies past key in scan order
    always_comb
    begin
        res.beyond = desc ? (key > ref_key) : (key < ref_key);
        res.equal  = (key == ref_key);
    end

endmodule
`default_nettype wire

// ===== sv/iss_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
module iss_seq
    import iss_pkg::*;
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire iss_req_t                       req,
    input  wire iss_cfg_t                       cfg,
    input  wire logic [KEY_W-1:0]               idx_rdata,
    input  wire logic [REC_W-1:0]               rec_rdata,
    output logic                                busy,
    output logic                                done,
    output iss_rsp_t                            rsp,
    output logic                                idx_we,
    output logic [PAGE_W-1:0]                   idx_waddr,
    output logic [KEY_W-1:0]                    idx_wdata,
    output logic [PAGE_W-1:0]                   idx_raddr,
    output logic                                rec_we,
    output logic [PAGE_W+SLOT_W-1:0]            rec_waddr,
    output logic [REC_W-1:0]                    rec_wdata,
    output logic [PAGE_W+SLOT_W-1:0]            rec_raddr
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_IDX,
        S_LAST,
        S_LCHK,
        S_PG
    } state_t;

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        a_reg, a_next;
    logic [CNT_W-1:0]        c_reg, c_next;
    logic                    dv_reg, dv_next;
    logic [PAGE_W-1:0]       page_reg, page_next;
    logic [PSIZE_W-1:0]      len_reg, len_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic                    done_reg, done_next;
    iss_rsp_t                rsp_reg, rsp_next;

    logic                    load_acc;
    logic signed [KEY_W-1:0] cmp_ref;
    iss_cmp_t                cmp;
    logic [PCNT_W-1:0]       n_m1;
    logic [CNT_W-1:0]        len_m1;
    logic [SLOT_W-1:0]       fill_m1;

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    // Loads write straight into the record store on acceptance, and into the page index for slot 0
    assign load_acc  = start && !busy && (req.action == ACT_LOAD);
    assign rec_we    = load_acc;
    assign rec_waddr = {req.page_number, req.slot};
    assign rec_wdata = {req.key, req.payload};
    assign idx_we    = load_acc && (req.slot == '0);
    assign idx_waddr = req.page_number;
    assign idx_wdata = req.key;

    // Scan addresses
    assign n_m1      = cfg.n - PCNT_W'(1);
    assign len_m1    = CNT_W'(len_reg) - CNT_W'(1);
    assign fill_m1   = SLOT_W'(cfg.fill - PSIZE_W'(1));
    assign idx_raddr = a_reg[PAGE_W-1:0];
    assign rec_raddr = (state_reg == S_LAST) ? {n_m1[PAGE_W-1:0], fill_m1}
                                             : {page_reg, a_reg[SLOT_W-1:0]};

    // One compare unit shared by index, last-record and page scans
    assign cmp_ref = (state_reg == S_IDX) ? $signed(idx_rdata)
                                          : $signed(rec_rdata[REC_W-1:PAYLOAD_WIDTH]);

    iss_cmp u_cmp (
        .key     (key_reg),
        .ref_key (cmp_ref),
        .desc    (cfg.desc),
        .res     (cmp)
    );

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        a_next     = a_reg;
        c_next     = c_reg;
        dv_next    = dv_reg;
        page_next  = page_reg;
        len_next   = len_reg;
        key_next   = key_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start && req.action == ACT_SEARCH)
                begin
                    key_next   = req.key;
                    a_next     = '0;
                    c_next     = '0;
                    dv_next    = 1'b0;
                    state_next = S_IDX;
                end
            end

            S_IDX:
            begin
                a_next  = a_reg + CNT_W'(1);
                dv_next = 1'b1;
                if (cfg.n == '0)
                begin
                    done_next  = 1'b1;
                    rsp_next   = '0;
                    state_next = S_IDLE;
                end
                else if (dv_reg)
                begin
                    c_next = c_reg + CNT_W'(1);
                    if (cmp.beyond)
                    begin
                        if (c_reg == '0)
                        begin
                            // page before the first
                            done_next  = 1'b1;
                            rsp_next   = '0;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            page_next  = c_reg[PAGE_W-1:0] - PAGE_W'(1);
                            len_next   = cfg.ps;
                            a_next     = '0;
                            c_next     = '0;
                            dv_next    = 1'b0;
                            state_next = S_PG;
                        end
                    end
                    else if (c_reg == CNT_W'(n_m1))
                    begin
                        if (cfg.desc)
                        begin
                            state_next = S_LAST;
                        end
                        else
                        begin
                            page_next  = n_m1[PAGE_W-1:0];
                            len_next   = cfg.fill;
                            a_next     = '0;
                            c_next     = '0;
                            dv_next    = 1'b0;
                            state_next = S_PG;
                        end
                    end
                end
            end

            S_LAST:
            begin
                state_next = S_LCHK;
            end

            // descending: key must be at least the last record's key
            S_LCHK:
            begin
                if (cmp.beyond || cmp.equal)
                begin
                    page_next  = n_m1[PAGE_W-1:0];
                    len_next   = cfg.fill;
                    a_next     = '0;
                    c_next     = '0;
                    dv_next    = 1'b0;
                    state_next = S_PG;
                end
                else
                begin
                    done_next  = 1'b1;
                    rsp_next   = '0;
                    state_next = S_IDLE;
                end
            end

            S_PG:
            begin
                a_next  = a_reg + CNT_W'(1);
                dv_next = 1'b1;
                if (dv_reg)
                begin
                    c_next = c_reg + CNT_W'(1);
                    if (cmp.beyond)
                    begin
                        done_next  = 1'b1;
                        rsp_next   = '0;
                        state_next = S_IDLE;
                    end
                    else if (cmp.equal)
                    begin
                        done_next              = 1'b1;
                        rsp_next.found         = 1'b1;
                        rsp_next.match_key     = rec_rdata[REC_W-1:PAYLOAD_WIDTH];
                        rsp_next.match_payload = rec_rdata[PAYLOAD_WIDTH-1:0];
                        state_next             = S_IDLE;
                    end
                    else if (c_reg == len_m1)
                    begin
                        done_next  = 1'b1;
                        rsp_next   = '0;
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            a_reg     <= '0;
            c_reg     <= '0;
            dv_reg    <= 1'b0;
            page_reg  <= '0;
            len_reg   <= '0;
            key_reg   <= '0;
            done_reg  <= 1'b0;
            rsp_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            a_reg     <= a_next;
            c_reg     <= c_next;
            dv_reg    <= dv_next;
            page_reg  <= page_next;
            len_reg   <= len_next;
            key_reg   <= key_next;
            done_reg  <= done_next;
            rsp_reg   <= rsp_next;
        end
    end

endmodule
`default_nettype wire

// ===== sv/iss_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none
module iss_chk
    import iss_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  start,
    input wire iss_req_t              req,
    input wire logic                  busy,
    input wire logic                  done,
    input wire iss_rsp_t              rsp
);

    // A result only ends a search in progress
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a search in progress");

    // After a result the block is free again
    a_idle_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("busy while delivering a result");

    // Miss carries zero key and payload
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !rsp.found) |-> (rsp.match_key == '0 && rsp.match_payload == '0))
        else $error("miss with nonzero fields");

    // Load request gives no result and no busy time
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req.action == ACT_LOAD) |=> (!busy && !done))
        else $error("load request caused activity");

    // Search request always starts the sequencer
    a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req.action == ACT_SEARCH) |=> busy)
        else $error("search request not started");

endmodule

bind indexed_sequential_search iss_chk u_iss_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .req       (req),
    .busy      (busy),
    .done      (done),
    .rsp       (rsp)
);
`default_nettype wire
